/* sv/aes_pkg.sv */
// ----------------------------------------------------------------------------
// AES package
// Shared S-box tables, field arithmetic helpers and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none
package aes_pkg;

  localparam int unsigned NumRounds = 10;

  localparam logic [1:0] REG_KEY_UPPER    = 2'd0;
  localparam logic [1:0] REG_KEY_LOWER    = 2'd1;
  localparam logic [1:0] REG_DECRYPT_MODE = 2'd2;

  typedef logic [127:0] block_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  localparam logic [7:0] RCON [10] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of the state sits at bits 127-8i downto 120-8i.
  function automatic logic [7:0] get_byte(input block_t s, input int unsigned i);
    get_byte = s[127 - 8*i -: 8];
  endfunction

endpackage
`default_nettype wire

/* sv/aes_key_expand.sv */
// ----------------------------------------------------------------------------
// AES key expansion
// Derives the eleven round keys from the cipher key, one round key per cycle,
// and holds them in registers for the round cells.
// ----------------------------------------------------------------------------
`default_nettype none
module aes_key_expand (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [127:0] key,
  output logic              busy,
  output logic      [127:0] round_keys [11]
);

  logic         running;
  logic [3:0]   round;
  logic [127:0] cur;
  logic [127:0] key_next;

  // One step of the schedule: rotate, substitute and add the round constant
  // to the last word, then ripple it through the four words.
  always_comb begin
    logic [31:0] t;
    t = {aes_pkg::SBOX[cur[23:16]] ^ aes_pkg::RCON[round - 4'd1], aes_pkg::SBOX[cur[15:8]],
         aes_pkg::SBOX[cur[7:0]], aes_pkg::SBOX[cur[31:24]]};
    key_next[127:96] = cur[127:96] ^ t;
    key_next[95:64]  = cur[95:64]  ^ key_next[127:96];
    key_next[63:32]  = cur[63:32]  ^ key_next[95:64];
    key_next[31:0]   = cur[31:0]   ^ key_next[63:32];
  end

  assign busy = start || running;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      round   <= 4'd1;
    end else if (start) begin
      running <= 1'b1;
      round   <= 4'd1;
    end else if (running) begin
      if (round == 4'(aes_pkg::NumRounds)) begin
        running <= 1'b0;
      end else begin
        round <= round + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cur           <= key;
      round_keys[0] <= key;
    end else if (running) begin
      cur               <= key_next;
      round_keys[round] <= key_next;
    end
  end

endmodule
`default_nettype wire

/* sv/aes_round_cell.sv */
// ----------------------------------------------------------------------------
// AES round cell
// One registered round of the cipher or inverse cipher; the block and its
// mode move on to the next cell in every cycle that the chain advances.
// ----------------------------------------------------------------------------
`default_nettype none
module aes_round_cell (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  advance,
  input  wire logic                  last,
  input  wire logic                  in_valid,
  input  wire logic                  in_decrypt,
  input  wire aes_pkg::block_t       in_state,
  input  wire aes_pkg::block_t       enc_key,
  input  wire aes_pkg::block_t       dec_key,
  output logic                       out_valid,
  output logic                       out_decrypt,
  output aes_pkg::block_t            out_state
);

  aes_pkg::block_t enc_ss, dec_ss, enc_mx, dec_mx, state_next;

  always_comb begin
    logic [7:0] a, b, c, d, all;
    logic [7:0] a2, a4, a8, b2, b4, b8, c2, c4, c8, d2, d4, d8;
    for (int col = 0; col < 4; col++) begin
      for (int r = 0; r < 4; r++) begin
        enc_ss[127 - 8*(4*col+r) -: 8] =
          aes_pkg::SBOX[aes_pkg::get_byte(in_state, 4*((col+r)%4)+r)];
        dec_ss[127 - 8*(4*((col+r)%4)+r) -: 8] =
          aes_pkg::INV_SBOX[aes_pkg::get_byte(in_state, 4*col+r)];
      end
    end
    for (int col = 0; col < 4; col++) begin
      a = aes_pkg::get_byte(enc_ss, 4*col);
      b = aes_pkg::get_byte(enc_ss, 4*col+1);
      c = aes_pkg::get_byte(enc_ss, 4*col+2);
      d = aes_pkg::get_byte(enc_ss, 4*col+3);
      all = a ^ b ^ c ^ d;
      enc_mx[127 - 32*col -: 32] = {a ^ all ^ aes_pkg::xtime(a ^ b),
                                    b ^ all ^ aes_pkg::xtime(b ^ c),
                                    c ^ all ^ aes_pkg::xtime(c ^ d),
                                    d ^ all ^ aes_pkg::xtime(d ^ a)};
    end
    // Inverse mixing works on the block after the round key is added.
    for (int col = 0; col < 4; col++) begin
      a = aes_pkg::get_byte(dec_ss ^ dec_key, 4*col);
      b = aes_pkg::get_byte(dec_ss ^ dec_key, 4*col+1);
      c = aes_pkg::get_byte(dec_ss ^ dec_key, 4*col+2);
      d = aes_pkg::get_byte(dec_ss ^ dec_key, 4*col+3);
      a2 = aes_pkg::xtime(a); a4 = aes_pkg::xtime(a2); a8 = aes_pkg::xtime(a4);
      b2 = aes_pkg::xtime(b); b4 = aes_pkg::xtime(b2); b8 = aes_pkg::xtime(b4);
      c2 = aes_pkg::xtime(c); c4 = aes_pkg::xtime(c2); c8 = aes_pkg::xtime(c4);
      d2 = aes_pkg::xtime(d); d4 = aes_pkg::xtime(d2); d8 = aes_pkg::xtime(d4);
      dec_mx[127 - 32*col -: 32] = {
        (a8^a4^a2) ^ (b8^b2^b) ^ (c8^c4^c) ^ (d8^d),
        (a8^a) ^ (b8^b4^b2) ^ (c8^c2^c) ^ (d8^d4^d),
        (a8^a4^a) ^ (b8^b) ^ (c8^c4^c2) ^ (d8^d2^d),
        (a8^a2^a) ^ (b8^b4^b) ^ (c8^c) ^ (d8^d4^d2)};
    end
    if (in_decrypt) begin
      state_next = last ? (dec_ss ^ dec_key) : dec_mx;
    end else begin
      state_next = (last ? enc_ss : enc_mx) ^ enc_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_decrypt <= in_decrypt;
      out_state   <= state_next;
    end
  end

endmodule
`default_nettype wire

/* sv/aes128_block_cipher_unit.sv */
// ----------------------------------------------------------------------------
// AES-128 block cipher unit
// ECB encryption or decryption through a chain of ten round cells.
// ----------------------------------------------------------------------------
// Usage: a block is offered as two 64-bit halves on block_upper and
// block_lower under in_valid/in_ready; each accepted beat yields one result
// beat on result_upper/result_lower under out_valid/out_ready, in order.
// The key and mode are set through the configuration channel (index 0 and 1
// for the key halves, index 2 for the mode) while the unit is idle.
// Writing either key half restarts the key schedule, which builds one round
// key per cycle; cfg_ready and in_ready stay low after the write until the
// schedule is built, and likewise after reset is released until it is built.
// On the way to the result, the initial key addition is registered at the
// accepting edge and each of the ten round cells adds one register. The unit
// takes one block per cycle while the chain advances and no key schedule is
// being built; the chain of round cells sets that rate.
// When the receiver stalls, the whole chain holds, and in_ready falls while
// the last cell carries a result that has not been taken.
// Reset clears all valid flags, sets the key to zero and selects encryption.
`default_nettype none
module aes128_block_cipher_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] block_upper,
  input  wire logic [63:0] block_lower,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      result_upper,
  output logic [63:0]      result_lower
);

  logic [63:0] key_upper, key_lower;
  logic        decrypt_mode;
  logic [127:0] round_keys [11];

  logic            cfg_accept;
  logic            key_write;
  logic            expand_start;
  logic            expand_busy;

  logic            advance;
  logic            chain_valid   [11];
  logic            chain_decrypt [11];
  aes_pkg::block_t chain_state   [11];

  // Configuration waits while the key schedule is being built.
  assign cfg_ready  = !expand_busy;
  assign cfg_accept = cfg_valid && cfg_ready;
  assign key_write  = cfg_accept &&
                      (cfg_index == aes_pkg::REG_KEY_UPPER ||
                       cfg_index == aes_pkg::REG_KEY_LOWER);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_upper    <= '0;
      key_lower    <= '0;
      decrypt_mode <= 1'b0;
    end else if (cfg_accept) begin
      case (cfg_index)
        aes_pkg::REG_KEY_UPPER:    key_upper    <= cfg_data;
        aes_pkg::REG_KEY_LOWER:    key_lower    <= cfg_data;
        aes_pkg::REG_DECRYPT_MODE: decrypt_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The schedule starts the cycle after a key write, once the key registers
  // hold the new value; reset starts it from the all-zero key.
  always_ff @(posedge clk) begin
    if (rst) begin
      expand_start <= 1'b1;
    end else begin
      expand_start <= key_write;
    end
  end

  aes_key_expand u_expand (
    .clk        (clk),
    .rst        (rst),
    .start      (expand_start),
    .key        ({key_upper, key_lower}),
    .busy       (expand_busy),
    .round_keys (round_keys)
  );

  // The chain moves whenever the last cell is empty or being drained.
  assign advance  = !chain_valid[10] || out_ready;
  assign in_ready = advance && !expand_busy;

  // Stage zero applies the initial round key: key 0 to encrypt, key 10 to decrypt.
  always_ff @(posedge clk) begin
    if (rst) begin
      chain_valid[0] <= 1'b0;
    end else if (advance) begin
      chain_valid[0] <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      chain_decrypt[0] <= decrypt_mode;
      chain_state[0]   <= {block_upper, block_lower} ^
                          (decrypt_mode ? round_keys[10] : round_keys[0]);
    end
  end

  for (genvar g = 1; g <= 10; g++) begin : g_cell
    aes_round_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .advance     (advance),
      .last        (g == 10),
      .in_valid    (chain_valid[g-1]),
      .in_decrypt  (chain_decrypt[g-1]),
      .in_state    (chain_state[g-1]),
      .enc_key     (round_keys[g]),
      .dec_key     (round_keys[10-g]),
      .out_valid   (chain_valid[g]),
      .out_decrypt (chain_decrypt[g]),
      .out_state   (chain_state[g])
    );
  end

  assign out_valid    = chain_valid[10];
  assign result_upper = chain_state[10][127:64];
  assign result_lower = chain_state[10][63:0];

endmodule
`default_nettype wire

/* sv/aes_checker.sv */
// ----------------------------------------------------------------------------
// AES port checker
// Watches the unit's ports for handshake and flow-control slips.
// ----------------------------------------------------------------------------
`default_nettype none
module aes_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cfg_ready,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] result_upper,
  input wire logic [63:0] result_lower
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_upper) && $stable(result_lower))
    else $error("result changed while stalled");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid && cfg_ready |-> in_ready)
    else $error("input blocked with empty output");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result shown after reset");

endmodule

bind aes128_block_cipher_unit aes_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .cfg_ready    (cfg_ready),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .result_upper (result_upper),
  .result_lower (result_lower)
);
`default_nettype wire
